// File: rtl/core/front_middle_back_queue_assert.svh
// Assertion macros for the front/middle/back queue.
// Each macro expands to one labeled concurrent assertion clocked on clk, off during rst.
`ifndef FRONT_MIDDLE_BACK_QUEUE_ASSERT_SVH
`define FRONT_MIDDLE_BACK_QUEUE_ASSERT_SVH

// Plain property that must hold at every edge out of reset
`define FMBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define FMBQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FMBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fmbq_pkg.sv
// Shared types and constants for the front/middle/back queue.
// No dependencies.
`timescale 1ns / 1ps

package fmbq_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CMD_WIDTH    = 3;
  localparam int VALUE_WIDTH  = 32;
  localparam int STATUS_WIDTH = 2;

  // Result word for anything that is not a successful pop
  localparam logic signed [VALUE_WIDTH-1:0] NO_VALUE = -32'sd1;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Where a half's write data comes from in the data stage
  typedef enum logic [1:0] {
    SRC_VALUE = 2'd0,
    SRC_FRONT = 2'd1,
    SRC_BACK  = 2'd2
  } src_t;

  // Data-stage work decided at accept time
  typedef struct packed {
    logic    front_we;
    logic    back_we;
    src_t    front_src;
    src_t    back_src;
    logic    pop_ok;
    logic    pop_from_back;
    status_t status;
  } plan_t;

endpackage

// File: rtl/core/fmbq_ram.sv
// Ring storage for one half of the queue: one write port, one registered read port.
// A read of the address written in the same cycle returns the new word.
`timescale 1ns / 1ps

module fmbq_ram #(
  parameter int DEPTH = 33,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read with write-through bypass
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// File: rtl/core/fmbq_plan.sv
// Head/count registers of both halves and the per-command address and move decision.
// Depends on fmbq_pkg.
`timescale 1ns / 1ps

module fmbq_plan
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [CMD_WIDTH-1:0]                  command,
  output plan_t                                 plan,
  output logic [$clog2(CAPACITY/2+1)-1:0]       front_raddr,
  output logic [$clog2(CAPACITY/2+1)-1:0]       back_raddr,
  output logic [$clog2(CAPACITY/2+1)-1:0]       front_waddr,
  output logic [$clog2(CAPACITY/2+1)-1:0]       back_waddr,
  output logic [$clog2(CAPACITY/2+2)-1:0]       front_count,
  output logic [$clog2(CAPACITY/2+2)-1:0]       back_count
);

  localparam int HALF_DEPTH = CAPACITY / 2 + 1;
  localparam int AW         = $clog2(HALF_DEPTH);
  localparam int CW         = $clog2(HALF_DEPTH + 1);
  localparam int TW         = $clog2(CAPACITY + 1);

  logic [AW-1:0] front_head, front_head_next, back_head, back_head_next;
  logic [CW-1:0] front_count_next, back_count_next;
  logic [AW-1:0] f_end, f_tail, f_hm1, f_hp1;
  logic [AW-1:0] b_end, b_tail, b_hm1, b_hp1;
  logic [TW-1:0] total;
  logic          full, empty;

  // Ring index arithmetic; k never exceeds the depth
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(k);
    if (s >= (CW+1)'(HALF_DEPTH)) begin
      s = s - (CW+1)'(HALF_DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(HALF_DEPTH - 1) : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == AW'(HALF_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  // Ring positions of interest
  always_comb begin
    f_end  = ring_add(front_head, front_count);
    f_tail = ring_dec(f_end);
    f_hm1  = ring_dec(front_head);
    f_hp1  = ring_inc(front_head);
    b_end  = ring_add(back_head, back_count);
    b_tail = ring_dec(b_end);
    b_hm1  = ring_dec(back_head);
    b_hp1  = ring_inc(back_head);
    total  = TW'(front_count) + TW'(back_count);
    full   = (total >= TW'(CAPACITY));
    empty  = (total == '0);
  end

  // Command decode: new heads and counts, read/write slots, data routing
  always_comb begin
    front_head_next  = front_head;
    back_head_next   = back_head;
    front_count_next = front_count;
    back_count_next  = back_count;
    front_raddr      = f_tail;
    back_raddr       = back_head;
    front_waddr      = f_end;
    back_waddr       = b_hm1;
    plan             = '{front_we: 1'b0, back_we: 1'b0, front_src: SRC_VALUE,
                         back_src: SRC_VALUE, pop_ok: 1'b0, pop_from_back: 1'b0,
                         status: ST_DONE};
    case (cmd_t'(command))
      CMD_PUSH_FRONT: begin
        if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.front_we   = 1'b1;
          front_waddr     = f_hm1;
          front_head_next = f_hm1;
          if (front_count > back_count) begin
            // old front tail spills to the back head
            plan.back_we    = 1'b1;
            plan.back_src   = SRC_FRONT;
            back_head_next  = b_hm1;
            back_count_next = back_count + CW'(1);
          end else begin
            front_count_next = front_count + CW'(1);
          end
        end
      end
      CMD_PUSH_MIDDLE: begin
        if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.front_we = 1'b1;
          if (front_count > back_count) begin
            // old middle moves back, new word takes its slot
            plan.back_we    = 1'b1;
            plan.back_src   = SRC_FRONT;
            back_head_next  = b_hm1;
            back_count_next = back_count + CW'(1);
            front_waddr     = f_tail;
          end else begin
            front_count_next = front_count + CW'(1);
          end
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.back_we = 1'b1;
          back_waddr   = b_end;
          if (front_count <= back_count) begin
            // back head joins the front tail; with an empty back it is the new word
            plan.front_we    = 1'b1;
            plan.front_src   = (back_count == '0) ? SRC_VALUE : SRC_BACK;
            back_head_next   = b_hp1;
            front_count_next = front_count + CW'(1);
          end else begin
            back_count_next = back_count + CW'(1);
          end
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.pop_ok     = 1'b1;
          front_raddr     = front_head;
          front_head_next = f_hp1;
          if (front_count <= back_count) begin
            plan.front_we   = 1'b1;
            plan.front_src  = SRC_BACK;
            back_head_next  = b_hp1;
            back_count_next = back_count - CW'(1);
          end else begin
            front_count_next = front_count - CW'(1);
          end
        end
      end
      CMD_POP_MIDDLE: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.pop_ok = 1'b1;
          if (front_count <= back_count) begin
            // back head refills the slot just emptied
            plan.front_we   = 1'b1;
            plan.front_src  = SRC_BACK;
            front_waddr     = f_tail;
            back_head_next  = b_hp1;
            back_count_next = back_count - CW'(1);
          end else begin
            front_count_next = front_count - CW'(1);
          end
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else if (back_count == '0) begin
          // single entry lives in the front half
          plan.pop_ok      = 1'b1;
          front_count_next = front_count - CW'(1);
        end else begin
          plan.pop_ok        = 1'b1;
          plan.pop_from_back = 1'b1;
          back_raddr         = b_tail;
          if (front_count > back_count) begin
            plan.back_we     = 1'b1;
            plan.back_src    = SRC_FRONT;
            back_head_next   = b_hm1;
            front_count_next = front_count - CW'(1);
          end else begin
            back_count_next = back_count - CW'(1);
          end
        end
      end
      default: begin
        plan.status = ST_DONE;
      end
    endcase
  end

  // Head and count registers advance once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      front_head  <= '0;
      front_count <= '0;
      back_head   <= '0;
      back_count  <= '0;
    end else if (accept) begin
      front_head  <= front_head_next;
      front_count <= front_count_next;
      back_head   <= back_head_next;
      back_count  <= back_count_next;
    end
  end

endmodule

// File: rtl/core/front_middle_back_queue.sv
// Front/middle/back queue of signed words, kept as two balanced ring halves.
// Input channel: in_valid/in_stall with command and value; one transaction per command.
// Output channel: out_valid/out_stall with popped_value and status, exactly one
// result transaction per command, in command order.
// An accepted command is held in the data stage register until the data stage fires,
// then its result is loaded into the result register. Throughput: one command per
// cycle while in_stall is low. Head/count bookkeeping is settled at accept, the half
// memories are read into their output registers on the same edge, and the data stage
// then writes both halves and loads the result register. A memory read that hits the
// slot written in that cycle is bypassed, so back-to-back commands see each other's moves.
// Reset clears both halves' heads and counts (queue empty) and the pipeline valids;
// stored words are not cleared and are never read before being written.
// When out_stall holds a pending result, one more command may sit in the data stage;
// after that in_stall rises until the result is taken.
// Depends on fmbq_pkg, fmbq_plan, fmbq_ram and front_middle_back_queue_assert.svh.
`timescale 1ns / 1ps
`include "front_middle_back_queue_assert.svh"

module front_middle_back_queue
  import fmbq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [CMD_WIDTH-1:0]           command,
  input  logic signed [VALUE_WIDTH-1:0]  value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [VALUE_WIDTH-1:0]  popped_value,
  output logic [STATUS_WIDTH-1:0]        status
);

  localparam int HALF_DEPTH = CAPACITY / 2 + 1;
  localparam int AW         = $clog2(HALF_DEPTH);
  localparam int CW         = $clog2(HALF_DEPTH + 1);

  plan_t                         plan, s1_plan;
  logic [AW-1:0]                 front_raddr, back_raddr, front_waddr, back_waddr;
  logic [AW-1:0]                 s1_front_waddr, s1_back_waddr;
  logic [CW-1:0]                 front_count, back_count;
  logic [DATA_WIDTH-1:0]         s1_word, front_rdata, back_rdata;
  logic [DATA_WIDTH-1:0]         front_wdata, back_wdata;
  logic signed [DATA_WIDTH-1:0]  pop_word;
  logic                          s1_valid, s1_adv, s1_fire, accept;
  logic                          front_we, back_we;

  // Handshake: data stage moves on when the result register is free or being taken
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = s1_valid && s1_adv;

  fmbq_plan #(
    .CAPACITY (CAPACITY)
  ) u_plan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .plan        (plan),
    .front_raddr (front_raddr),
    .back_raddr  (back_raddr),
    .front_waddr (front_waddr),
    .back_waddr  (back_waddr),
    .front_count (front_count),
    .back_count  (back_count)
  );

  // Data stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_plan        <= plan;
      s1_front_waddr <= front_waddr;
      s1_back_waddr  <= back_waddr;
      s1_word        <= DATA_WIDTH'(value);
    end
  end

  // Write data routing between the halves
  always_comb begin
    case (s1_plan.front_src)
      SRC_BACK: front_wdata = back_rdata;
      default:  front_wdata = s1_word;
    endcase
    case (s1_plan.back_src)
      SRC_FRONT: back_wdata = front_rdata;
      default:   back_wdata = s1_word;
    endcase
  end

  assign front_we = s1_fire && s1_plan.front_we;
  assign back_we  = s1_fire && s1_plan.back_we;

  fmbq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_front_ram (
    .clk   (clk),
    .we    (front_we),
    .waddr (s1_front_waddr),
    .wdata (front_wdata),
    .re    (accept),
    .raddr (front_raddr),
    .rdata (front_rdata)
  );

  fmbq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_back_ram (
    .clk   (clk),
    .we    (back_we),
    .waddr (s1_back_waddr),
    .wdata (back_wdata),
    .re    (accept),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

  assign pop_word = s1_plan.pop_from_back ? back_rdata : front_rdata;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      popped_value <= s1_plan.pop_ok ? VALUE_WIDTH'(pop_word) : NO_VALUE;
      status       <= s1_plan.status;
    end
  end

  // Checks
  `FMBQ_ASSERT(a_halves_balanced, (front_count - back_count) <= CW'(1), "halves out of balance")
  `FMBQ_ASSERT(a_within_capacity, (front_count + back_count) <= CAPACITY, "over capacity")
  `FMBQ_ASSERT_NEXT(a_result_loaded, s1_fire, out_valid, "data stage retired without a result")
  `FMBQ_ASSERT_IMPL(a_refused_no_word, out_valid && (status != ST_DONE),
                    popped_value == NO_VALUE, "failed command returned a word")

endmodule

// File: verif/tb_front_middle_back_queue.sv
// Self-checking testbench for front_middle_back_queue: a directed table, then
// random command phases, checked against a two-half queue predictor kept here.
// Depends on fmbq_pkg and the front_middle_back_queue RTL.
`timescale 1ns / 1ps

module tb_front_middle_back_queue;
  import fmbq_pkg::*;

  localparam int QUEUE_DEPTH   = DEF_CAPACITY;
  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AT_ITEM  = 400;
  localparam int SETTLE_CYCLES = 8;

  // Command codes outside cmd_t; the block treats them as no-ops
  localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_B = 3'd7;

  // Mix of commands in a random phase
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  localparam logic [VALUE_WIDTH-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_WIDTH-1:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] popped;
    status_t                       status;
  } result_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0]   cmd;
    logic [VALUE_WIDTH-1:0] word;
    logic                   typed;
    logic [VALUE_WIDTH-1:0] popped;
    status_t                status;
  } step_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [CMD_WIDTH-1:0]          command = '0;
  logic signed [VALUE_WIDTH-1:0] value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [VALUE_WIDTH-1:0] popped_value;
  logic [STATUS_WIDTH-1:0]       status;

  // Typed expectation that travels with a directed transaction
  logic                   row_typed = 1'b0;
  logic [VALUE_WIDTH-1:0] row_popped = '0;
  status_t                row_status = ST_DONE;

  logic [VALUE_WIDTH-1:0] front_half_q[$];
  logic [VALUE_WIDTH-1:0] back_half_q[$];
  result_t                pending_results[$];
  int                     mismatch_count = 0;
  int                     items_sent = 0;
  int                     burst_left = 0;

  // Directed rows: empty pops, unused codes, single entry popped from the back,
  // extreme words, middle pushes and pops down to empty
  step_row_t directed_steps [DIRECTED_ROWS] = '{
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b1, NO_VALUE,      ST_EMPTY},
    '{CMD_POP_MIDDLE,  32'h0000_0000, 1'b1, NO_VALUE,      ST_EMPTY},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b1, NO_VALUE,      ST_EMPTY},
    '{CMD_UNUSED_A,    32'h1234_5678, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_UNUSED_B,    32'h8765_4321, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_PUSH_BACK,   WORD_MIN,      1'b1, NO_VALUE,      ST_DONE},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b1, WORD_MIN,      ST_DONE},
    '{CMD_PUSH_FRONT,  WORD_MAX,      1'b1, NO_VALUE,      ST_DONE},
    '{CMD_PUSH_MIDDLE, 32'h0000_0000, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_PUSH_MIDDLE, 32'hffff_ffff, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_PUSH_BACK,   32'h5555_5555, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_PUSH_FRONT,  32'haaaa_aaaa, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_POP_MIDDLE,  32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_POP_MIDDLE,  32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_POP_MIDDLE,  32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_POP_MIDDLE,  32'h0000_0000, 1'b1, NO_VALUE,      ST_EMPTY},
    '{CMD_PUSH_MIDDLE, 32'h0000_0001, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_PUSH_MIDDLE, 32'h0000_0002, 1'b1, NO_VALUE,      ST_DONE},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b0, NO_VALUE,      ST_DONE},
    '{CMD_UNUSED_A,    32'hffff_ffff, 1'b1, NO_VALUE,      ST_DONE}
  };

  front_middle_back_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keep the front half at ceil(n/2) entries by moving one word across
  function automatic void balance_halves();
    logic [VALUE_WIDTH-1:0] w;
    if (front_half_q.size() > back_half_q.size() + 1) begin
      w = front_half_q[front_half_q.size() - 1];
      front_half_q.delete(front_half_q.size() - 1);
      back_half_q = {w, back_half_q};
    end else if (front_half_q.size() < back_half_q.size()) begin
      w = back_half_q[0];
      back_half_q.delete(0);
      front_half_q = {front_half_q, w};
    end
  endfunction

  // Apply one command to the queue copy and return the result it produces.
  // Words are full width here, so no masking or sign extension is needed.
  function automatic result_t apply_command(logic [CMD_WIDTH-1:0] cmd,
                                            logic [VALUE_WIDTH-1:0] word);
    result_t                r;
    int                     total;
    logic [VALUE_WIDTH-1:0] w;
    r.popped = NO_VALUE;
    r.status = ST_DONE;
    total = front_half_q.size() + back_half_q.size();
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
        if (total >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          front_half_q = {word, front_half_q};
          balance_halves();
        end else if (cmd == CMD_PUSH_MIDDLE) begin
          // middle push: make room so the word lands at floor(n/2)
          if (front_half_q.size() > back_half_q.size()) begin
            w = front_half_q[front_half_q.size() - 1];
            front_half_q.delete(front_half_q.size() - 1);
            back_half_q = {w, back_half_q};
          end
          front_half_q = {front_half_q, word};
        end else begin
          back_half_q = {back_half_q, word};
          balance_halves();
        end
      end
      CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
        if (total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // pop back with an empty back half takes the lone front entry
          if (cmd == CMD_POP_FRONT) begin
            r.popped = front_half_q[0];
            front_half_q.delete(0);
          end else if (cmd == CMD_POP_MIDDLE || back_half_q.size() == 0) begin
            r.popped = front_half_q[front_half_q.size() - 1];
            front_half_q.delete(front_half_q.size() - 1);
          end else begin
            r.popped = back_half_q[back_half_q.size() - 1];
            back_half_q.delete(back_half_q.size() - 1);
          end
          balance_halves();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one transaction, hold it until accepted, then maybe idle
  task automatic offer(input logic [CMD_WIDTH-1:0] cmd, input logic [VALUE_WIDTH-1:0] word,
                       input logic typed, input logic [VALUE_WIDTH-1:0] pop_exp,
                       input status_t st_exp);
    command    <= cmd;
    value      <= word;
    row_typed  <= typed;
    row_popped <= pop_exp;
    row_status <= st_exp;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 10);
    end
  endtask

  // Stimulus: reset, directed table, random phases, drain
  initial begin
    int                     mix;
    int                     phase_idx;
    int                     phase_left;
    int                     push_pct;
    int                     roll;
    logic [CMD_WIDTH-1:0]   cmd;
    logic [VALUE_WIDTH-1:0] word;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i])
      offer(directed_steps[i].cmd, directed_steps[i].word, directed_steps[i].typed,
            directed_steps[i].popped, directed_steps[i].status);

    // First phase is push-heavy (fill), second pop-heavy (drain), the rest pick a random mix
    phase_idx  = 0;
    phase_left = 0;
    mix        = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        if (phase_idx == 0)      mix = MIX_FILL;
        else if (phase_idx == 1) mix = MIX_DRAIN;
        else                     mix = $urandom_range(MIX_FILL, MIX_EVEN);
        phase_left = (phase_idx < 2) ? 140 : $urandom_range(40, 140);
        phase_idx++;
      end
      phase_left--;
      push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;

      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        cmd = roll[0] ? CMD_UNUSED_A : CMD_UNUSED_B;
      end else if ($urandom_range(0, 99) < push_pct) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_PUSH_FRONT;
          1:       cmd = CMD_PUSH_MIDDLE;
          default: cmd = CMD_PUSH_BACK;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_POP_FRONT;
          1:       cmd = CMD_POP_MIDDLE;
          default: cmd = CMD_POP_BACK;
        endcase
      end

      // mostly full-range words, some extremes
      case ($urandom_range(0, 11))
        0:       word = '0;
        1:       word = '1;
        2:       word = WORD_MAX;
        3:       word = WORD_MIN;
        default: word = $urandom();
      endcase

      offer(cmd, word, 1'b0, NO_VALUE, ST_DONE);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Receiver stall pattern, plus one long hold-off that backs up the input side
  initial begin
    int  mode;
    bit  held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(10, 60)) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Predict on input transactions, check output transactions in order
  always @(posedge clk) begin : scoreboard
    result_t predicted;
    result_t oldest;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted = apply_command(command, value);
        if (row_typed) begin
          predicted.popped = row_popped;
          predicted.status = row_status;
        end
        pending_results = {pending_results, predicted};
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: popped %0d status %0d", popped_value, status);
          mismatch_count++;
        end else begin
          oldest = pending_results[0];
          pending_results.delete(0);
          if (popped_value !== oldest.popped || status !== oldest.status) begin
            if (mismatch_count < 10)
              $display("mismatch: expected popped %0d status %0d, got popped %0d status %0d",
                       oldest.popped, oldest.status, popped_value, status);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fmbq_pkg.sv
rtl/core/fmbq_ram.sv
rtl/core/fmbq_plan.sv
rtl/core/front_middle_back_queue.sv
verif/tb_front_middle_back_queue.sv
